@@ design/largest_square_of_ones_defines.svh @@
// Assertion macros shared by the largest_square_of_ones RTL.
// Include by bare file name; every macro expects signals clock and reset in scope.
`ifndef LARGEST_SQUARE_OF_ONES_DEFINES_SVH
`define LARGEST_SQUARE_OF_ONES_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define LSQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define LSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/lsq_pkg.sv @@
// Shared types and constants for the largest_square_of_ones block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lsq_pkg;

   localparam int SIDE_W     = 11;
   localparam int AREA_W     = 21;
   localparam int WIDTH_W    = 11;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = SIDE_W + AREA_W;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;

   typedef logic [SIDE_W-1:0] side_type;
   typedef logic [AREA_W-1:0] area_type;

   // One result: area in the upper bits, side in the lower bits
   typedef struct packed {
      area_type area;
      side_type side;
   } result_type;

endpackage

@@ design/lsq_line_store.sv @@
// Line store: one side value per column, registered read with write bypass.
// Depends on lsq_pkg for the side type.
`timescale 1ns / 1ps

module lsq_line_store
   import lsq_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  side_type          wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output side_type          rd_data
);

   side_type mem [DEPTH];

   side_type rd_ff;
   logic     byp_ff;
   side_type byp_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // Remember a write that hits the address being read this cycle
   always_ff @(posedge clock) begin
      byp_ff      <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= wr_data;
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

@@ design/lsq_out_buf.sv @@
// Two-entry result buffer between the compute logic and the rsp channel.
// Depends on lsq_pkg for result_type and on the assertion macro header.
`timescale 1ns / 1ps
`include "largest_square_of_ones_defines.svh"

module lsq_out_buf
   import lsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       head_valid_ff;
   logic       skid_valid_ff;
   result_type head_ff;
   result_type skid_ff;
   logic       head_free;

   assign in_ready  = !skid_valid_ff;
   assign head_free = !head_valid_ff || out_ready;

   // Valid flags: refill head from skid first, then from the new request
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (head_free) begin
         head_valid_ff <= skid_valid_ff || in_valid;
         skid_valid_ff <= skid_valid_ff && in_valid;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload moves; no reset needed
   always_ff @(posedge clock) begin
      if (head_free) begin
         if (skid_valid_ff) begin
            head_ff <= skid_ff;
            skid_ff <= in_data;
         end else begin
            head_ff <= in_data;
         end
      end else if (in_valid) begin
         skid_ff <= in_data;
      end
   end

   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

   `LSQ_ASSERT_NOW(a_skid_needs_head, skid_valid_ff, head_valid_ff, "skid holds data without head")
   `LSQ_ASSERT_NEXT(a_stall_keeps_head, head_valid_ff && !out_ready, head_valid_ff && $stable(head_ff), "stalled result lost")

endmodule

@@ design/largest_square_of_ones.sv @@
// Largest all-ones square of a binary raster image.
// Channels:
//   req_*  : one pixel per request, raster order; req_tdata[0] = pixel_set,
//            req_tlast = image_end (final pixel of the image).
//   rsp_*  : one result per image; rsp_tdata[10:0] = max_side,
//            rsp_tdata[31:11] = max_area.
//   csr_*  : write of image_width (pixels per row); 0 acts as 1 and values
//            above MAX_WIDTH act as MAX_WIDTH. A write restarts the image.
// Throughput: one pixel per cycle while req_tready is high; the line store
// has one write and one registered read per cycle, the read address being
// the next pixel's column. The result reaches rsp from a registered buffer.
// Reset: image_width returns to 1024 and the block waits for the first pixel
// of a new image; the line store is not cleared (every entry read in an image
// was written earlier in that image).
// Stall: results queue in a two-entry buffer; pixels keep flowing until both
// entries hold results, then req_tready drops until rsp_tready takes one.
`timescale 1ns / 1ps
`include "largest_square_of_ones_defines.svh"

module largest_square_of_ones
   import lsq_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: bit 0 pixel_set, upper bits zero
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   // rsp_tdata: [10:0] max_side, [31:11] max_area
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WIDTH_W-1:0]    csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [WIDTH_W-1:0] width_ff;
   logic               first_row_ff, first_row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   side_type           left_ff, left_in;
   side_type           upleft_ff, upleft_in;
   side_type           best_ff, best_in;

   logic [31:0]        width_eff;
   logic [COL_W-1:0]   row_last;
   logic               accept;
   logic               col_last;
   side_type           above, left, upleft, min_lu, min3, side, best_new;
   side_type           rd_data;
   logic [2*SIDE_W-1:0] area_full;
   result_type         result;
   logic               push_ready;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;

   // Effective row length, clamped to 1..MAX_WIDTH
   always_comb begin
      width_eff = {{(32-WIDTH_W){1'b0}}, width_ff};
      if (width_eff == 32'd0) begin
         width_eff = 32'd1;
      end else if (width_eff > 32'(MAX_WIDTH)) begin
         width_eff = 32'(MAX_WIDTH);
      end
      row_last = COL_W'(width_eff - 32'd1);
   end

   // Neighbors, with zeros outside the image
   always_comb begin
      above    = first_row_ff ? '0 : rd_data;
      left     = (col_ff == '0) ? '0 : left_ff;
      upleft   = ((col_ff == '0) || first_row_ff) ? '0 : upleft_ff;
      min_lu   = (left < upleft) ? left : upleft;
      min3     = (above < min_lu) ? above : min_lu;
      side     = req_tdata[0] ? side_type'(min3 + side_type'(1)) : '0;
      best_new = (side > best_ff) ? side : best_ff;
      col_last = (col_ff == row_last);
   end

   // Next per-image state
   always_comb begin
      first_row_in = first_row_ff;
      col_in       = col_ff;
      left_in      = left_ff;
      upleft_in    = upleft_ff;
      best_in      = best_ff;
      if (csr_valid) begin
         first_row_in = 1'b1;
         col_in       = '0;
         left_in      = '0;
         upleft_in    = '0;
         best_in      = '0;
      end else if (accept) begin
         upleft_in = above;
         left_in   = side;
         if (req_tlast) begin
            first_row_in = 1'b1;
            col_in       = '0;
            best_in      = '0;
         end else begin
            best_in = best_new;
            if (col_last) begin
               first_row_in = 1'b0;
               col_in       = '0;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   // Hold configuration and per-image state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         first_row_ff <= 1'b1;
         col_ff       <= '0;
         left_ff      <= '0;
         upleft_ff    <= '0;
         best_ff      <= '0;
      end else begin
         if (csr_valid) begin
            width_ff <= csr_data;
         end
         first_row_ff <= first_row_in;
         col_ff       <= col_in;
         left_ff      <= left_in;
         upleft_ff    <= upleft_in;
         best_ff      <= best_in;
      end
   end

   // Line store: write this column, read the next pixel's column
   lsq_line_store #(
      .DEPTH (MAX_WIDTH),
      .ADDR_W(COL_W)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(col_ff),
      .wr_data(side),
      .rd_addr(col_in),
      .rd_data(rd_data)
   );

   // Result for the final pixel
   assign area_full   = {{SIDE_W{1'b0}}, best_new} * {{SIDE_W{1'b0}}, best_new};
   assign result.side = best_new;
   assign result.area = area_full[AREA_W-1:0];

   lsq_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept && req_tlast),
      .in_ready (push_ready),
      .in_data  (result),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_tdata)
   );

   assign req_tready = push_ready;

   `LSQ_ASSERT_NOW(a_col_in_row, 1'b1, col_ff <= row_last, "column beyond row length")
   `LSQ_ASSERT_NEXT(a_end_clears, accept && req_tlast, first_row_ff && (best_ff == '0) && (col_ff == '0), "image end did not clear state")

endmodule
